// File: hw/rtl/mmcal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcal_pkg
// Types and constants shared by the magnetometer min/max calibration core.
// ----------------------------------------------------------------------------
package mmcal_pkg;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_START   = 2'd1,
    OP_SAMPLE  = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  // decoded item passed from front to back
  typedef struct packed {
    op_t                op;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } mmcal_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/mmcal_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcal_front
// Assembles burst bytes into axis words (X and Y negated, saturating) and
// queues decoded items for the back end.
// ----------------------------------------------------------------------------
module mmcal_front
  import mmcal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_y_high,
  input  wire logic [7:0]  in_y_low,
  input  wire logic [7:0]  in_z_high,
  input  wire logic [7:0]  in_z_low,
  input  wire logic [7:0]  in_x_high,
  input  wire logic [7:0]  in_x_low,
  output logic             q_valid,
  output mmcal_item_t      q_item,
  input  wire logic        q_take
);

  mmcal_item_t       mem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push_ok, pop_ok;
  mmcal_item_t       itm;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    neg_sat = (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  always_comb begin
    itm.op = op_t'(in_operation);
    itm.vy = neg_sat({in_y_high, in_y_low});
    itm.vz = {in_z_high, in_z_low};
    itm.vx = neg_sat({in_x_high, in_x_low});
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop_ok  = q_take && q_valid;
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= itm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (pop_ok) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop_ok) else $error("pop from empty queue");
  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok && !pop_ok |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count");

endmodule
`default_nettype wire

// File: hw/rtl/mmcal_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcal_div
// Restoring divider, one quotient bit a cycle: floor(num * 2^F / den),
// saturated to the scale width.
// ----------------------------------------------------------------------------
module mmcal_div #(
  parameter int unsigned F = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] num,
  input  wire logic [16:0] den,
  output logic             done,
  output logic [23:0]      quo
);
  localparam int unsigned QW = 17 + F;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] q_r;
  logic [17:0]   rem_r;
  logic [16:0]   den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [17:0]   sh;
  logic [QW-1:0] dvd;

  assign dvd = {num, {F{1'b0}}};
  assign sh  = {rem_r[16:0], q_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; cnt_r <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dvd; rem_r <= '0; den_r <= den;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_r <= sh - {1'b0, den_r};
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = (den_r == '0 || |q_r[QW-1:24]) ? 24'hffffff : q_r[23:0];

endmodule
`default_nettype wire

// File: hw/rtl/mmcal_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmcal_back
// Holds calibration state, runs finish through a shared divider and measure
// through one multiplier, three axes in turn, into a one-entry output stage.
// ----------------------------------------------------------------------------
module mmcal_back
  import mmcal_pkg::*;
#(
  parameter int unsigned F  = 16,
  parameter int unsigned OF = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire mmcal_item_t        q_item,
  output logic                    q_take,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [31:0]      out_x_out,
  output logic signed [31:0]      out_y_out,
  output logic signed [31:0]      out_z_out,
  output logic                    out_calibrated
);
  localparam int unsigned SH = F + 1 - OF;

  bk_state_t st_r, st_nxt;
  logic signed [15:0] mn_r [3];
  logic signed [15:0] mx_r [3];
  logic signed [17:0] off_r [3];
  logic [23:0]        scl_r [3];
  logic               cal_r;
  mmcal_item_t        it_r;
  logic [1:0]         ax_r;
  logic [1:0]         dstep_r;
  logic [23:0]        rx_s_r, ry_s_r;   // xs, ys from first two divisions
  logic signed [31:0] res_r [3];
  logic               full_r;
  logic signed [43:0] prod_r;
  logic               prod_v_r;

  logic [16:0] rng [3];
  logic        dstart;
  logic [1:0]  dsel;
  logic [16:0] dnum, dden;
  logic        ddone;
  logic [23:0] dquo;
  logic signed [15:0] vsel;
  logic signed [17:0] sum;
  logic signed [43:0] rsum;
  logic signed [43:0] rnd;
  logic signed [31:0] satv;

  mmcal_div #(.F(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [16:0] d;
      d = 17'(mx_r[i]) - 17'(mn_r[i]);
      rng[i] = d[16] ? 17'd0 : d;
    end
  end

  // divisions: 0 ry/rx, 1 rx/ry, 2 z ratio; operands are for the one starting
  assign dsel = (st_r == BK_IDLE) ? 2'd0 : dstep_r + 2'd1;

  always_comb begin
    case (dsel)
      2'd0:    begin dnum = rng[1]; dden = rng[0]; end
      2'd1:    begin dnum = rng[0]; dden = rng[1]; end
      default: begin
        dnum = (rx_s_r > dquo) ? rng[1] : rng[0];
        dden = rng[2];
      end
    endcase
  end

  always_comb begin
    case (ax_r)
      2'd0:    vsel = it_r.vx;
      2'd1:    vsel = it_r.vy;
      default: vsel = it_r.vz;
    endcase
    sum  = (18'(vsel) <<< 1) + off_r[ax_r];
    rsum = prod_r + 44'sd2 ** (SH - 1);
    rnd  = rsum >>> SH;
    if (rnd > 44'sd2147483647)       satv = 32'sh7fffffff;
    else if (rnd < -44'sd2147483648) satv = 32'sh80000000;
    else                             satv = rnd[31:0];
  end

  assign q_take = (st_r == BK_IDLE) && q_valid && !full_r;
  assign dstart = (q_take && q_item.op == OP_FINISH) ||
                  (st_r == BK_DIV && ddone && dstep_r != 2'd2);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_take) begin
        if (q_item.op == OP_FINISH) st_nxt = BK_DIV;
        else if (q_item.op == OP_MEASURE && cal_r) st_nxt = BK_MUL;
        else st_nxt = BK_OUT;
      end
      BK_DIV: if (ddone && dstep_r == 2'd2) st_nxt = BK_OUT;
      BK_MUL: if (prod_v_r && ax_r == 2'd2) st_nxt = BK_OUT;
      BK_OUT: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; cal_r <= 1'b0; full_r <= 1'b0; prod_v_r <= 1'b0;
      ax_r <= '0; dstep_r <= '0;
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= '0; mx_r[i] <= '0; off_r[i] <= '0; scl_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_pop && full_r) full_r <= 1'b0;
      case (st_r)
        BK_IDLE: if (q_take) begin
          it_r <= q_item; ax_r <= '0; dstep_r <= '0; prod_v_r <= 1'b0;
          if (q_item.op == OP_START) begin
            cal_r <= 1'b0;
            mn_r[0] <= q_item.vx; mx_r[0] <= q_item.vx;
            mn_r[1] <= q_item.vy; mx_r[1] <= q_item.vy;
            mn_r[2] <= q_item.vz; mx_r[2] <= q_item.vz;
          end else if (q_item.op == OP_SAMPLE) begin
            if (q_item.vx < mn_r[0]) mn_r[0] <= q_item.vx;
            if (q_item.vx > mx_r[0]) mx_r[0] <= q_item.vx;
            if (q_item.vy < mn_r[1]) mn_r[1] <= q_item.vy;
            if (q_item.vy > mx_r[1]) mx_r[1] <= q_item.vy;
            if (q_item.vz < mn_r[2]) mn_r[2] <= q_item.vz;
            if (q_item.vz > mx_r[2]) mx_r[2] <= q_item.vz;
          end else if (q_item.op == OP_FINISH) begin
            for (int i = 0; i < 3; i++)
              off_r[i] <= -(18'(mx_r[i]) + 18'(mn_r[i]));
          end
        end
        BK_DIV: if (ddone) begin
          dstep_r <= dstep_r + 2'd1;
          if (dstep_r == 2'd0) rx_s_r <= dquo;
          else if (dstep_r == 2'd1) begin
            ry_s_r <= dquo;
            if (rx_s_r > dquo) begin
              scl_r[0] <= rx_s_r; scl_r[1] <= 24'(32'd1 << F);
            end else begin
              scl_r[1] <= dquo;   scl_r[0] <= 24'(32'd1 << F);
            end
          end else begin
            scl_r[2] <= dquo; cal_r <= 1'b1;
          end
        end
        BK_MUL: begin
          prod_r   <= 44'(sum) * $signed({1'b0, scl_r[ax_r]});
          prod_v_r <= !prod_v_r;
          if (prod_v_r) begin
            res_r[ax_r] <= satv;
            ax_r <= ax_r + 2'd1;
          end
        end
        BK_OUT: full_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // output stage: zeros on finish; products on calibrated measure; else v << OF
  logic signed [31:0] ox, oy, oz;
  always_comb begin
    if (it_r.op == OP_FINISH) begin
      ox = '0; oy = '0; oz = '0;
    end else if (it_r.op == OP_MEASURE && cal_r) begin
      ox = res_r[0]; oy = res_r[1]; oz = res_r[2];
    end else begin
      ox = 32'(it_r.vx) <<< OF; oy = 32'(it_r.vy) <<< OF; oz = 32'(it_r.vz) <<< OF;
    end
  end

  assign out_empty      = !full_r;
  assign out_x_out      = ox;
  assign out_y_out      = oy;
  assign out_z_out      = oz;
  assign out_calibrated = cal_r;

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == BK_IDLE && !full_r) else $error("take while busy");
  a_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_OUT |=> full_r) else $error("result lost");
  a_div_cal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_DIV && ddone && dstep_r == 2'd2 |=> cal_r) else $error("cal");
  a_ry_use: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_MUL |-> cal_r && ry_s_r == ry_s_r) else $error("mul");

endmodule
`default_nettype wire

// File: hw/rtl/magnetometer_minmax_calibration_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_core
// Hard-iron min/max calibration with axis scaling for a 3-axis magnetometer.
// ----------------------------------------------------------------------------
// Result paths: raw items go straight to the output stage; a corrected measure
// uses one multiplier shared over the three axes in turn; finish runs three
// divisions on one shared bit-serial divider.
// One item in the back end at a time, the next taken the cycle after its result
// is popped; a two-entry queue lets the input side keep taking items meanwhile.
// Reset: synchronous, active low; clears min/max, offsets, scales and queues.
module magnetometer_minmax_calibration_core
  import mmcal_pkg::*;
#(
  parameter int unsigned SCALE_FRACTION_BITS  = 16,
  parameter int unsigned OUTPUT_FRACTION_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_y_high,
  input  wire logic [7:0]  in_y_low,
  input  wire logic [7:0]  in_z_high,
  input  wire logic [7:0]  in_z_low,
  input  wire logic [7:0]  in_x_high,
  input  wire logic [7:0]  in_x_low,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_z_out,
  output logic             out_calibrated
);
  logic        q_valid, q_take;
  mmcal_item_t q_item;

  mmcal_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_operation,
    .in_y_high, .in_y_low, .in_z_high, .in_z_low, .in_x_high, .in_x_low,
    .q_valid, .q_item, .q_take
  );

  mmcal_back #(.F(SCALE_FRACTION_BITS), .OF(OUTPUT_FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .out_empty, .out_pop,
    .out_x_out, .out_y_out, .out_z_out, .out_calibrated
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Magnetometer min/max calibration core testbench
// Drives burst samples with all four operations through the input queue,
// predicts each result in a local model of min/max, offsets and scales, and
// compares every popped result field by field. Random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import mmcal_pkg::*;

  localparam int SFB = 16;
  localparam int OFB = 4;
  localparam int SCALE_SAT = 24'hFFFFFF;
  localparam int N_RANDOM = 800;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               cal;
  } field_t;

  typedef struct {
    op_t        op;
    logic [7:0] b[6];
    logic       known;
    field_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_operation = '0;
  logic [7:0] in_y_high = '0, in_y_low = '0, in_z_high = '0;
  logic [7:0] in_z_low = '0, in_x_high = '0, in_x_low = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_x_out, out_y_out, out_z_out;
  logic out_calibrated;

  magnetometer_minmax_calibration_core #(
    .SCALE_FRACTION_BITS (SFB),
    .OUTPUT_FRACTION_BITS(OFB)
  ) dut (
    .clk, .rst_n, .in_push, .in_full, .in_operation,
    .in_y_high, .in_y_low, .in_z_high, .in_z_low, .in_x_high, .in_x_low,
    .out_empty, .out_pop, .out_x_out, .out_y_out, .out_z_out, .out_calibrated
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [15:0] ax_min[3], ax_max[3];
  logic signed [17:0] ax_off[3];
  logic [23:0]        ax_scale[3];
  logic               cal_valid;

  field_t expected_fields[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_ops[4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;
  longint cycles = 0;

  function automatic logic [23:0] ratio24(longint num, longint den);
    longint q;
    if (den == 0) return SCALE_SAT;
    q = (num << SFB) / den;
    return (q > SCALE_SAT) ? SCALE_SAT : q[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] correct_axis(longint v, longint off, longint sc);
    longint p;
    p = (2 * v + off) * sc;
    // arithmetic shift gives floor, so adding half rounds ties upwards
    return sat32((p + (64'sd1 <<< (SFB - OFB))) >>> (SFB + 1 - OFB));
  endfunction

  function automatic field_t predict_field(op_t op, logic [7:0] b[6]);
    field_t f;
    longint v[3];
    longint r[3];
    logic [23:0] xs, ys, zs;
    logic signed [15:0] w;
    w = {b[0], b[1]}; v[1] = (w == -16'sd32768) ? 32767 : -longint'(w);
    w = {b[2], b[3]}; v[2] = w;
    w = {b[4], b[5]}; v[0] = (w == -16'sd32768) ? 32767 : -longint'(w);
    if (op == OP_FINISH) begin
      for (int i = 0; i < 3; i++) begin
        r[i] = longint'(ax_max[i]) - longint'(ax_min[i]);
        if (r[i] < 0) r[i] = 0;
        ax_off[i] = -(longint'(ax_max[i]) + longint'(ax_min[i]));
      end
      xs = ratio24(r[1], r[0]);
      ys = ratio24(r[0], r[1]);
      if (xs > ys) begin
        ys = 24'd1 << SFB;
        zs = ratio24(r[1], r[2]);
      end else begin
        zs = ratio24(r[0], r[2]);
        xs = 24'd1 << SFB;
      end
      ax_scale[0] = xs; ax_scale[1] = ys; ax_scale[2] = zs;
      cal_valid = 1'b1;
      f.x = 0; f.y = 0; f.z = 0; f.cal = 1'b1;
      return f;
    end
    if (op == OP_START) begin
      cal_valid = 1'b0;
      for (int i = 0; i < 3; i++) begin
        ax_min[i] = v[i]; ax_max[i] = v[i];
      end
    end else if (op == OP_SAMPLE) begin
      for (int i = 0; i < 3; i++) begin
        if (v[i] < ax_min[i]) ax_min[i] = v[i];
        if (v[i] > ax_max[i]) ax_max[i] = v[i];
      end
    end
    if (op == OP_MEASURE && cal_valid) begin
      f.x = correct_axis(v[0], ax_off[0], ax_scale[0]);
      f.y = correct_axis(v[1], ax_off[1], ax_scale[1]);
      f.z = correct_axis(v[2], ax_off[2], ax_scale[2]);
    end else begin
      f.x = sat32(v[0] * (1 << OFB));
      f.y = sat32(v[1] * (1 << OFB));
      f.z = sat32(v[2] * (1 << OFB));
    end
    f.cal = cal_valid;
    return f;
  endfunction

  task automatic push_sample(op_t op, logic [7:0] b[6]);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_operation <= op;
    in_y_high <= b[0]; in_y_low <= b[1];
    in_z_high <= b[2]; in_z_low <= b[3];
    in_x_high <= b[4]; in_x_low <= b[5];
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_fields.push_back(predict_field(op, b));
    n_ops[op]++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: random pop bursts, compare against oldest expectation
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    field_t e;
    cycles <= cycles + 1;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", out_x_out);
      end else begin
        e = expected_fields.pop_front();
        n_checked++;
        if (out_x_out !== e.x || out_y_out !== e.y || out_z_out !== e.z
            || out_calibrated !== e.cal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%0d y=%0d z=%0d c=%0b got x=%0d y=%0d z=%0d c=%0b",
                     n_checked, e.x, e.y, e.z, e.cal,
                     out_x_out, out_y_out, out_z_out, out_calibrated);
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t dir[$];
    row_t rw;
    logic [7:0] b[6];
    field_t got;
    int cnt;
    op_t op;

    for (int i = 0; i < 3; i++) begin
      ax_min[i] = 0; ax_max[i] = 0; ax_off[i] = 0; ax_scale[i] = 0;
    end
    cal_valid = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: {op, Yh, Yl, Zh, Zl, Xh, Xl}
    rw.known = 1'b0;
    rw.op = OP_MEASURE; rw.b = '{0, 0, 0, 0, 0, 0}; rw.known = 1;
    rw.res = '{x: 0, y: 0, z: 0, cal: 0}; dir.push_back(rw);
    // finish before any start: zero ranges saturate
    rw.op = OP_FINISH; rw.b = '{8'h12, 8'h34, 0, 0, 0, 0};
    rw.res = '{x: 0, y: 0, z: 0, cal: 1}; dir.push_back(rw);
    rw.known = 0;
    rw.op = OP_MEASURE; rw.b = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01};
    dir.push_back(rw);
    // -32768 on X and Y saturates on negation
    rw.op = OP_START; rw.b = '{8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00}; rw.known = 1;
    rw.res = '{x: 32767 * 16, y: 32767 * 16, z: -32768 * 16, cal: 0}; dir.push_back(rw);
    rw.op = OP_SAMPLE; rw.b = '{8'h7f, 8'hff, 8'h7f, 8'hff, 8'h7f, 8'hff};
    rw.res = '{x: -32767 * 16, y: -32767 * 16, z: 32767 * 16, cal: 0}; dir.push_back(rw);
    rw.known = 0;
    rw.op = OP_FINISH; rw.b = '{0, 0, 0, 0, 0, 0}; dir.push_back(rw);
    rw.op = OP_MEASURE; rw.b = '{8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00}; dir.push_back(rw);
    rw.op = OP_MEASURE; rw.b = '{8'h7f, 8'hff, 8'h7f, 8'hff, 8'h7f, 8'hff}; dir.push_back(rw);
    // X range wide, Y narrow: X kept at one
    rw.op = OP_START; rw.b = '{8'h00, 8'h10, 8'h00, 8'h00, 8'h10, 8'h00}; dir.push_back(rw);
    rw.op = OP_SAMPLE; rw.b = '{8'hff, 8'hf0, 8'h00, 8'h20, 8'hf0, 8'h00}; dir.push_back(rw);
    rw.op = OP_FINISH; dir.push_back(rw);
    rw.op = OP_MEASURE; rw.b = '{8'h01, 8'h00, 8'hff, 8'h00, 8'h00, 8'h40}; dir.push_back(rw);
    // Y range wide, X narrow
    rw.op = OP_START; rw.b = '{8'h20, 8'h00, 8'h01, 8'h00, 8'h00, 8'h05}; dir.push_back(rw);
    rw.op = OP_SAMPLE; rw.b = '{8'he0, 8'h00, 8'hff, 8'h00, 8'hff, 8'hfb}; dir.push_back(rw);
    rw.op = OP_FINISH; dir.push_back(rw);
    rw.op = OP_MEASURE; rw.b = '{8'h55, 8'haa, 8'h33, 8'hcc, 8'h0f, 8'hf0}; dir.push_back(rw);
    // sample without start keeps the flag, then a start clears it
    rw.op = OP_SAMPLE; rw.b = '{8'h40, 8'h00, 8'hc0, 8'h00, 8'h40, 8'h00}; dir.push_back(rw);
    rw.op = OP_START; dir.push_back(rw);
    rw.op = OP_MEASURE; dir.push_back(rw);

    foreach (dir[i]) begin
      if (dir[i].known) begin
        got = predict_field(dir[i].op, dir[i].b);
        if (got != dir[i].res) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d disagrees with table", i);
        end
        // restore: recompute by replaying is unnecessary, state updates matched
        expected_fields.push_back(dir[i].res);
        n_ops[dir[i].op]++;
        in_push <= 1'b1;
        in_operation <= dir[i].op;
        in_y_high <= dir[i].b[0]; in_y_low <= dir[i].b[1];
        in_z_high <= dir[i].b[2]; in_z_low <= dir[i].b[3];
        in_x_high <= dir[i].b[4]; in_x_low <= dir[i].b[5];
        @(posedge clk);
        while (in_full) @(posedge clk);
        @(negedge clk);
      end else begin
        push_sample(dir[i].op, dir[i].b);
      end
    end

    // random: mostly well-formed calibrations with measures, some noise
    cnt = 0;
    while (cnt < N_RANDOM) begin
      if (cnt > N_RANDOM - 80) no_idle = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        for (int k = 0; k < 6; k++) b[k] = rand_byte();
        push_sample(OP_START, b); cnt++;
        repeat ($urandom_range(1, 8)) begin
          for (int k = 0; k < 6; k++) b[k] = rand_byte();
          push_sample(OP_SAMPLE, b); cnt++;
        end
        push_sample(OP_FINISH, b); cnt++;
        repeat ($urandom_range(1, 10)) begin
          for (int k = 0; k < 6; k++) b[k] = rand_byte();
          push_sample(OP_MEASURE, b); cnt++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          for (int k = 0; k < 6; k++) b[k] = 8'($urandom_range(0, 255));
          op = op_t'($urandom_range(0, 3));
          push_sample(op, b); cnt++;
        end
      end
    end
    in_push <= 1'b0;

    while (expected_fields.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d results: %0d measure, %0d start, %0d sample, %0d finish",
             n_checked, n_ops[OP_MEASURE], n_ops[OP_START], n_ops[OP_SAMPLE],
             n_ops[OP_FINISH]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mmcal_pkg.sv
hw/rtl/mmcal_front.sv
hw/rtl/mmcal_div.sv
hw/rtl/mmcal_back.sv
hw/rtl/magnetometer_minmax_calibration_core.sv
tb/tb.sv
